// ===== src/crc16rb_pkg.sv =====
// crc16rb_pkg: shared types, constants and crc helper functions
// for the reflected byte-stream crc-16 block; no dependencies
`timescale 1ns / 1ps

package crc16rb_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8005;

   // word held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } byte_stage_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] x;
      x = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
      x = ((x & 8'hCC) >> 2) | ((x & 8'h33) << 2);
      x = ((x & 8'hF0) >> 4) | ((x & 8'h0F) << 4);
      return x;
   endfunction

   function automatic logic [15:0] rev_in_bytes(input logic [15:0] v);
      logic [15:0] x;
      x = ((v & 16'hAAAA) >> 1) | ((v & 16'h5555) << 1);
      x = ((x & 16'hCCCC) >> 2) | ((x & 16'h3333) << 2);
      x = ((x & 16'hF0F0) >> 4) | ((x & 16'h0F0F) << 4);
      return x;
   endfunction

   // eight msb-first shift steps, unrolled into xor logic
   function automatic logic [15:0] absorb(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc ^ {rev8(data), 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== src/crc16rb_ifs.sv =====
// crc16rb channel interfaces: byte request and crc response
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps

interface crc16rb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16rb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink (input valid, input crc_value, output ready);
endinterface

// ===== src/crc16_reflected_byte_stream.sv =====
// crc16_reflected_byte_stream: top level, input register plus crc core
// depends on crc16rb_pkg, crc16rb_ifs, crc16rb_in_stage, crc16rb_core
// latency: an accepted last byte passes the input register, then the result register, before its crc word shows on rsp
// throughput: one byte word per cycle, except that a last byte waits while a held result is stalled on rsp
// reset: synchronous active high; clears both valid flags, running crc to 0xffff
`timescale 1ns / 1ps

module crc16_reflected_byte_stream
   import crc16rb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   crc16rb_req_if.sink          req_chan,
   crc16rb_rsp_if.source        rsp_chan
);

   // word sitting in the input register
   byte_stage_type stage;
   // core takes the held word this cycle
   logic           stage_take;

   // input register: refills in the same cycle its word moves on
   crc16rb_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data_byte (req_chan.data_byte),
      .req_last_byte (req_chan.last_byte),
      .stage_take    (stage_take),
      .stage         (stage)
   );

   // crc update, running value and result register; result parts the two sides
   crc16rb_core u_core (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .stage_take    (stage_take),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_crc_value (rsp_chan.crc_value)
   );

endmodule

// ===== src/crc16rb_in_stage.sv =====
// crc16rb_in_stage: input register for one byte word
// depends on crc16rb_pkg
`timescale 1ns / 1ps

module crc16rb_in_stage
   import crc16rb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_data_byte,
   input  logic           req_last_byte,
   input  logic           stage_take,
   output byte_stage_type stage
);

   byte_stage_type stage_ff, stage_in;

   // free when empty or when the held word moves on this cycle
   assign req_ready = !stage_ff.valid || stage_take;
   assign stage     = stage_ff;

   always_comb begin
      stage_in = stage_ff;
      if (req_ready) begin
         stage_in.valid     = req_valid;
         stage_in.data_byte = req_data_byte;
         stage_in.last_byte = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.data_byte <= stage_in.data_byte;
      stage_ff.last_byte <= stage_in.last_byte;
   end

endmodule

// ===== src/crc16rb_core.sv =====
// crc16rb_core: running crc register, byte update and result register
// depends on crc16rb_pkg
`timescale 1ns / 1ps

module crc16rb_core
   import crc16rb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  byte_stage_type stage,
   output logic           stage_take,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [15:0]    rsp_crc_value
);

   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_crc_ff, out_crc_in;
   logic        out_free;
   logic [15:0] crc_next;

   assign out_free   = !out_valid_ff || rsp_ready;
   // a non-last byte never needs the result register
   assign stage_take = stage.valid && (!stage.last_byte || out_free);
   assign crc_next   = absorb(crc_ff, stage.data_byte);

   always_comb begin
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_crc_in   = out_crc_ff;
      if (stage_take) begin
         if (stage.last_byte) begin
            crc_in       = CRC_INIT;
            out_valid_in = 1'b1;
            out_crc_in   = rev_in_bytes(crc_next);
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
      out_crc_ff <= out_crc_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;

endmodule

// ===== src/crc16rb_checker.sv =====
// crc16rb_checker: port-level assertions for the crc block
// bound to crc16_reflected_byte_stream; no package dependency
`timescale 1ns / 1ps

module crc16rb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_crc_value
);

   // stalled result word keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // stalled result word keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_crc_value))
      else $error("rsp word changed while stalled");

   // a fresh result follows a last byte accepted through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte, 2))
      else $error("result without a last byte");

   // a draining output never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   // nothing is shown straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind crc16_reflected_byte_stream crc16rb_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_last_byte (req_chan.last_byte),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_crc_value (rsp_chan.crc_value)
);
